// File: hw/rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types, codes and sizes of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Table and code sizes
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int VB_W         = 4;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int PCNT_W       = 3;
  localparam int TBL_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Longest code that is kept: bounded by the parameter and by the word width
  localparam int LEN_LIM      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Bytes one encode can complete, and the aligned accumulator width
  localparam int MAX_BYTES    = (PEND_W + CODE_W) / BYTE_W;
  localparam int ACC_W        = (MAX_BYTES + 1) * BYTE_W;
  localparam int CNT_W        = $clog2(MAX_BYTES + 1);

  // Item kinds; the fourth code is ignored
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // One code table entry
  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Bytes handed from the packer to the emitter
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 count;
    logic [VB_W-1:0]                  vb;
  } group_t;

endpackage

// File: hw/rtl/hcbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_in_if / hcbp_out_if
// Valid/ready channels carrying input items and packed output bytes.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [hcbp_pkg::SYM_W-1:0]        symbol;
  logic [hcbp_pkg::CODE_W-1:0]       code_word;
  logic [hcbp_pkg::LEN_W-1:0]        code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                              valid;
  logic                              ready;
  logic [hcbp_pkg::BYTE_W-1:0]       packed_byte;
  logic [hcbp_pkg::VB_W-1:0]         valid_bits;
  logic                              last;

  modport source (output valid, packed_byte, valid_bits, last, input ready);
  modport sink   (input valid, packed_byte, valid_bits, last, output ready);
endinterface

// File: hw/rtl/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// Bytes are offered from the result register, behind the item and table registers.
// Throughput: one item per cycle while the output is ready and each item yields
//   at most one byte; an item of n bytes (up to 4) holds the output until sent.
// Reset: clears the table's valid bits (every symbol reads zero length at
//   once), the pending bits and the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table, bit accumulator and byte output.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  logic                   in_fire;
  logic                   sym_hit;
  logic                   grp_valid;
  logic                   grp_ready;
  hcbp_pkg::entry_t       wr_entry;
  hcbp_pkg::entry_t       rd_entry;
  hcbp_pkg::group_t       grp;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign sym_hit = ({1'b0, in_ch.symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));

  // Clamp the stored length to the longest code kept
  always_comb begin
    wr_entry.word = in_ch.code_word;
    wr_entry.len  = in_ch.code_length;
    if (in_ch.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIM)) begin
      wr_entry.len = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIM);
    end
  end

  hcbp_code_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_fire && (in_ch.kind == hcbp_pkg::KIND_LOAD) && sym_hit),
    .wr_addr  (in_ch.symbol[hcbp_pkg::TBL_IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (in_fire),
    .rd_hit   (sym_hit),
    .rd_addr  (in_ch.symbol[hcbp_pkg::TBL_IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  hcbp_bit_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .entry     (rd_entry),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  hcbp_byte_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_ch    (out_ch)
  );

endmodule

// File: hw/rtl/hcbp_code_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code word and length store with per-entry valid bits and registered read.
// ----------------------------------------------------------------------------
module hcbp_code_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [hcbp_pkg::TBL_IDX_W-1:0]   wr_addr,
  input  hcbp_pkg::entry_t                 wr_entry,
  input  logic                             rd_en,
  input  logic                             rd_hit,
  input  logic [hcbp_pkg::TBL_IDX_W-1:0]   rd_addr,
  output hcbp_pkg::entry_t                 rd_entry
);

  hcbp_pkg::entry_t                  mem [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::SYMBOL_COUNT-1:0] entry_valid;
  hcbp_pkg::entry_t                  rd_data;
  logic                              rd_valid;

  // Write the store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Mark written entries; reset leaves every symbol at zero length
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= rd_hit && entry_valid[rd_addr];
    end
  end

  // Unwritten or out of range entries read as zero length
  always_comb begin
    rd_entry = rd_data;
    if (!rd_valid) begin
      rd_entry = '0;
    end
  end

endmodule

// File: hw/rtl/hcbp_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_bit_packer
// Item register and bit accumulator: merges a code with the pending bits
// and splits off every completed byte in one pass.
// ----------------------------------------------------------------------------
module hcbp_bit_packer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [1:0]       in_kind,
  output logic             in_ready,
  input  hcbp_pkg::entry_t entry,
  output logic             grp_valid,
  input  logic             grp_ready,
  output hcbp_pkg::group_t grp
);

  logic                           item_valid;
  logic                           item_flush;
  logic [hcbp_pkg::PEND_W-1:0]    pend;        // left aligned, zero padded
  logic [hcbp_pkg::PCNT_W-1:0]    pend_cnt;
  logic [hcbp_pkg::PEND_W-1:0]    pend_next;
  logic [hcbp_pkg::PCNT_W-1:0]    pend_cnt_next;
  logic [hcbp_pkg::CODE_W-1:0]    word_la;
  logic [hcbp_pkg::ACC_W-1:0]     acc;
  logic [hcbp_pkg::LEN_W-1:0]     total;
  logic [hcbp_pkg::CNT_W-1:0]     nbytes;
  logic                           advance;

  // Left align the code; bits above its length fall off the top
  assign word_la = entry.word << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - entry.len);

  // Pending bits first, then the code right behind them
  assign acc = {pend, (hcbp_pkg::ACC_W - hcbp_pkg::PEND_W)'(0)}
             | ({word_la, (hcbp_pkg::ACC_W - hcbp_pkg::CODE_W)'(0)} >> pend_cnt);

  assign total  = hcbp_pkg::LEN_W'(pend_cnt) + entry.len;
  assign nbytes = hcbp_pkg::CNT_W'(total >> 3);

  // Build the output group and the leftover bits
  always_comb begin
    grp           = '0;
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    if (item_flush) begin
      grp.bytes[0]  = {pend, 1'b0};
      grp.count     = (pend_cnt != '0) ? hcbp_pkg::CNT_W'(1) : '0;
      grp.vb        = hcbp_pkg::VB_W'(pend_cnt);
      pend_next     = '0;
      pend_cnt_next = '0;
    end else begin
      for (int k = 0; k < hcbp_pkg::MAX_BYTES; k++) begin
        grp.bytes[k] = acc[hcbp_pkg::ACC_W-1-k*hcbp_pkg::BYTE_W -: hcbp_pkg::BYTE_W];
      end
      grp.count     = nbytes;
      grp.vb        = hcbp_pkg::VB_W'(hcbp_pkg::BYTE_W);
      pend_cnt_next = total[hcbp_pkg::PCNT_W-1:0];
      pend_next     = '0;
      for (int k = 0; k <= hcbp_pkg::MAX_BYTES; k++) begin
        if (nbytes == hcbp_pkg::CNT_W'(k)) begin
          pend_next = acc[hcbp_pkg::ACC_W-1-k*hcbp_pkg::BYTE_W -: hcbp_pkg::PEND_W];
        end
      end
    end
  end

  // Groups without bytes only update the accumulator
  assign grp_valid = item_valid && (grp.count != '0);
  assign advance   = item_valid && ((grp.count == '0) || grp_ready);
  assign in_ready  = !item_valid || advance;

  // Hold the item until its bytes are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_fire) begin
      item_valid <= (in_kind == hcbp_pkg::KIND_ENCODE) || (in_kind == hcbp_pkg::KIND_FLUSH);
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_flush <= (in_kind == hcbp_pkg::KIND_FLUSH);
    end
  end

  // Advance the accumulator as the item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      pend_cnt <= '0;
    end else if (advance) begin
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end
  end

endmodule

// File: hw/rtl/hcbp_byte_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_byte_emitter
// Result register: shifts a group of bytes out one transfer at a time.
// ----------------------------------------------------------------------------
module hcbp_byte_emitter (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_valid,
  output logic             grp_ready,
  input  hcbp_pkg::group_t grp,
  hcbp_out_if.source       out_ch
);

  logic [hcbp_pkg::MAX_BYTES-1:0][hcbp_pkg::BYTE_W-1:0] bytes;
  logic [hcbp_pkg::CNT_W-1:0]                          cnt;
  logic [hcbp_pkg::VB_W-1:0]                           vb;
  logic                                                out_fire;

  assign out_fire  = out_ch.valid && out_ch.ready;
  assign grp_ready = (cnt == '0) || ((cnt == hcbp_pkg::CNT_W'(1)) && out_ch.ready);

  assign out_ch.valid       = (cnt != '0);
  assign out_ch.packed_byte = bytes[0];
  assign out_ch.valid_bits  = vb;
  assign out_ch.last        = (cnt == hcbp_pkg::CNT_W'(1));

  // Count the bytes still to send
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (grp_valid && grp_ready) begin
      cnt <= grp.count;
    end else if (out_fire) begin
      cnt <= cnt - hcbp_pkg::CNT_W'(1);
    end
  end

  // Load a new group or drop the byte just sent
  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      bytes <= grp.bytes;
      vb    <= grp.vb;
    end else if (out_fire) begin
      for (int k = 0; k < hcbp_pkg::MAX_BYTES - 1; k++) begin
        bytes[k] <= bytes[k+1];
      end
      bytes[hcbp_pkg::MAX_BYTES-1] <= '0;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman code bit packer: loads code table
// entries, encodes byte streams and flushes, predicts every packed byte in a
// local bit accumulator and compares each output transfer in order.
// ----------------------------------------------------------------------------
module tb;
  import hcbp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         MAX_WAIT    = 18;
  localparam int         HOLD_CYCLES = 300;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         DRAIN_TAIL  = 20;

  typedef struct {
    logic [BYTE_W-1:0] packed_byte;
    logic [VB_W-1:0]   valid_bits;
    logic              last;
  } out_byte_t;

  logic clk;
  logic rst;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the code table and the bit accumulator
  logic [CODE_W-1:0] code_words [SYMBOL_COUNT];
  logic [LEN_W-1:0]  code_lens  [SYMBOL_COUNT];
  logic [PEND_W-1:0] acc_bits;
  logic [PCNT_W-1:0] acc_count;

  out_byte_t   packed_q [$];
  int          error_count;
  int          idle_cycles;
  bit          tx_no_gap;
  bit          rx_no_stall;
  bit          hold_req;
  logic [7:0]  hot_syms [8];

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Append one item's effect to the accumulator and queue the bytes it completes
  task automatic pack_item(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word,
                           input logic [LEN_W-1:0] len);
    int        code_len;
    int        total;
    int        produced;
    logic [63:0] acc;
    out_byte_t ob;
    begin
      produced = 0;
      case (kind)
        KIND_LOAD: begin
          if (sym < SYMBOL_COUNT) begin
            code_words[sym] = word;
            code_lens[sym]  = (len > LEN_LIM) ? LEN_W'(LEN_LIM) : len;
          end
        end
        KIND_ENCODE: begin
          if (sym < SYMBOL_COUNT) begin
            code_len = code_lens[sym];
            total    = acc_count + code_len;
            acc      = (64'(acc_bits) << code_len) |
                       (64'(code_words[sym]) & ((64'd1 << code_len) - 64'd1));
            while (total >= BYTE_W) begin
              ob.packed_byte = acc[total-1 -: BYTE_W];
              ob.valid_bits  = VB_W'(BYTE_W);
              ob.last        = 1'b0;
              packed_q.push_back(ob);
              total    -= BYTE_W;
              produced += 1;
            end
            if (produced > 0) packed_q[packed_q.size()-1].last = 1'b1;
            acc_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
            acc_count = PCNT_W'(total);
          end
        end
        KIND_FLUSH: begin
          if (acc_count != 0) begin
            ob.packed_byte = BYTE_W'({1'b0, acc_bits} << (BYTE_W - acc_count));
            ob.valid_bits  = VB_W'(acc_count);
            ob.last        = 1'b1;
            packed_q.push_back(ob);
            acc_bits  = '0;
            acc_count = '0;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Offer one item after a random gap; predict once it transfers
  task automatic send_item(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word,
                           input logic [LEN_W-1:0] len);
    int gap;
    begin
      gap = tx_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_ch.valid       <= 1'b1;
      in_ch.kind        <= kind;
      in_ch.symbol      <= sym;
      in_ch.code_word   <= word;
      in_ch.code_length <= len;
      do @(posedge clk); while (!in_ch.ready);
      pack_item(kind, sym, word, len);
    end
  endtask

  // Draw one item: mostly encodes of loaded symbols, some loads, flushes and noise
  task automatic send_random_item();
    int              pick;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    begin
      pick = $urandom_range(0, 99);
      sym  = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255))
                                         : hot_syms[$urandom_range(0, 7)];
      len  = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 63))
                                         : LEN_W'($urandom_range(1, 32));
      if (pick < 15)      send_item(KIND_LOAD, sym, $urandom, len);
      else if (pick < 85) send_item(KIND_ENCODE, sym, $urandom, len);
      else if (pick < 95) send_item(KIND_FLUSH, sym, $urandom, len);
      else                send_item(KIND_UNUSED, sym, $urandom, len);
    end
  endtask

  // Compare one output transfer with the oldest queued byte
  task automatic check_byte();
    out_byte_t exp_b;
    begin
      if (packed_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte %h vb %0d last %0b", $time,
                 out_ch.packed_byte, out_ch.valid_bits, out_ch.last);
      end else begin
        exp_b = packed_q.pop_front();
        if (out_ch.packed_byte !== exp_b.packed_byte ||
            out_ch.valid_bits !== exp_b.valid_bits || out_ch.last !== exp_b.last) begin
          error_count++;
          $display("%0t: expected byte %h vb %0d last %0b, got byte %h vb %0d last %0b",
                   $time, exp_b.packed_byte, exp_b.valid_bits, exp_b.last,
                   out_ch.packed_byte, out_ch.valid_bits, out_ch.last);
        end
      end
    end
  endtask

  // Receiver: stall at random per byte, hold off for a long stretch on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_byte();
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Empty table right after reset: encodes, flush and the unused kind give nothing
  task automatic test_reset_state();
    begin
      send_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
      send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    end
  endtask

  // Extremes of code length, saturation, four-byte encodes and partial flushes
  task automatic test_directed_codes();
    begin
      send_item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
      send_item(KIND_LOAD, 8'hFF, 32'hA5A5_A5A5, 6'd63);
      send_item(KIND_LOAD, 8'h01, 32'hFFFF_FFFE, 6'd1);
      send_item(KIND_LOAD, 8'h02, 32'h0000_007F, 6'd7);
      send_item(KIND_LOAD, 8'h03, 32'hFFFF_FFFF, 6'd0);
      send_item(KIND_LOAD, 8'h04, 32'h1234_5678, 6'd40);
      // 7 pending plus 32 bits: four full bytes
      send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
      send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
      send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'h04, 32'h0, 6'd0);
      send_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      send_item(KIND_UNUSED, 8'h02, 32'hFFFF_FFFF, 6'd5);
      // exactly one byte from 7 + 1 bits
      send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
      send_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
      // overwrite an entry, then use it
      send_item(KIND_LOAD, 8'h02, 32'h0, 6'd8);
      send_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
      send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    end
  endtask

  // Random streams over a small set of loaded symbols
  task automatic test_random_stream(input int n_items);
    begin
      foreach (hot_syms[i]) begin
        hot_syms[i] = SYM_W'($urandom_range(0, 255));
        send_item(KIND_LOAD, hot_syms[i], $urandom, LEN_W'($urandom_range(1, 32)));
      end
      repeat (n_items) send_random_item();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering long codes
  task automatic test_output_backpressure();
    begin
      send_item(KIND_LOAD, hot_syms[0], $urandom, 6'd32);
      send_item(KIND_LOAD, hot_syms[1], $urandom, 6'd31);
      hold_req  = 1'b1;
      tx_no_gap = 1'b1;
      repeat (40) send_item(KIND_ENCODE, hot_syms[$urandom_range(0, 1)], $urandom, 6'd0);
      tx_no_gap = 1'b0;
    end
  endtask

  // Back-to-back transfers on both sides
  task automatic test_full_rate();
    begin
      tx_no_gap   = 1'b1;
      rx_no_stall = 1'b1;
      repeat (40) send_random_item();
      tx_no_gap   = 1'b0;
      rx_no_stall = 1'b0;
    end
  endtask

  // Sequence the tests, drain and report
  initial begin
    error_count       = 0;
    tx_no_gap         = 1'b0;
    rx_no_stall       = 1'b0;
    hold_req          = 1'b0;
    acc_bits          = '0;
    acc_count         = '0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_LOAD;
    in_ch.symbol      = '0;
    in_ch.code_word   = '0;
    in_ch.code_length = '0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      code_words[i] = '0;
      code_lens[i]  = '0;
    end
    foreach (hot_syms[i]) hot_syms[i] = 8'(i);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_codes();
    test_random_stream(340);
    test_output_backpressure();
    test_full_rate();

    // Drop valid and wait for every queued byte
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (packed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
